>>> hw/rtl/mbps_pkg.sv
// Shared types and constants for the masked byte pattern search block.
// Depends on nothing; every other file of the block refers to it by scoped names.
package mbps_pkg;

  localparam int unsigned PAT_BYTES = 32;
  localparam int unsigned ADDR_W    = 6;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned CNT_CMP_W = 8;

  // Register index, taken from paddr[5:3] (registers sit on 8-byte steps).
  typedef enum logic [2:0] {
    REG_PATTERN0 = 3'd0,
    REG_PATTERN1 = 3'd1,
    REG_PATTERN2 = 3'd2,
    REG_PATTERN3 = 3'd3,
    REG_CARE     = 3'd4,
    REG_LENGTH   = 3'd5
  } reg_idx_t;

  // Pattern byte i lives in pattern[i], so the packed array equals
  // {pattern_word3, pattern_word2, pattern_word1, pattern_word0}.
  typedef struct packed {
    logic [PAT_BYTES-1:0][7:0] pattern;
    logic [PAT_BYTES-1:0]      care;
    logic [LEN_W-1:0]          length;
  } cfg_t;

  // Control of the window stage as seen by the matcher.
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

>>> hw/rtl/mbps_cfg_regs.sv
// Configuration register file with an APB-style slave port.
// Depends on mbps_pkg for the register index codes and the configuration struct.
module mbps_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mbps_pkg::ADDR_W-1:0]  paddr,
  input  logic [mbps_pkg::DATA_W-1:0]  pwdata,
  output logic [mbps_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output mbps_pkg::cfg_t               cfg
);

  mbps_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = mbps_pkg::reg_idx_t'(paddr[5:3]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        mbps_pkg::REG_PATTERN0: cfg.pattern[7:0]   <= pwdata;
        mbps_pkg::REG_PATTERN1: cfg.pattern[15:8]  <= pwdata;
        mbps_pkg::REG_PATTERN2: cfg.pattern[23:16] <= pwdata;
        mbps_pkg::REG_PATTERN3: cfg.pattern[31:24] <= pwdata;
        mbps_pkg::REG_CARE:     cfg.care           <= pwdata[31:0];
        mbps_pkg::REG_LENGTH:   cfg.length         <= pwdata[mbps_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mbps_pkg::REG_PATTERN0: prdata = cfg.pattern[7:0];
      mbps_pkg::REG_PATTERN1: prdata = cfg.pattern[15:8];
      mbps_pkg::REG_PATTERN2: prdata = cfg.pattern[23:16];
      mbps_pkg::REG_PATTERN3: prdata = cfg.pattern[31:24];
      mbps_pkg::REG_CARE:     prdata = mbps_pkg::DATA_W'(cfg.care);
      mbps_pkg::REG_LENGTH:   prdata = mbps_pkg::DATA_W'(cfg.length);
      default:                prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/mbps_window.sv
// Input stage: sliding byte window, byte count and buffer position registers.
// Depends on mbps_pkg for the stage control struct.
module mbps_window #(
  parameter int unsigned MAX_PATTERN_BYTES = 32,
  parameter int unsigned OFFSET_BITS       = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            data_byte,
  input  logic                                  last_byte,
  input  logic                                  take,
  output mbps_pkg::stage_ctl_t                  ctl,
  output logic [MAX_PATTERN_BYTES-1:0][7:0]     win,
  output logic [$clog2(MAX_PATTERN_BYTES+1)-1:0] seen,
  output logic [OFFSET_BITS-1:0]                pos
);

  localparam int unsigned SEEN_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam logic [SEEN_W-1:0]      SEEN_TOP = SEEN_W'(MAX_PATTERN_BYTES);
  localparam logic [OFFSET_BITS-1:0] POS_TOP  = '1;

  logic                              accept;
  logic [MAX_PATTERN_BYTES-1:0][7:0] win_next;
  logic [SEEN_W-1:0]                 seen_next;
  logic [OFFSET_BITS-1:0]            pos_next;

  // The registers hold the item now in the stage. When that item closed a
  // buffer, the next item starts from a cleared window, count and position.
  assign in_ready = ~ctl.valid | take;
  assign accept   = in_valid & in_ready;

  always_comb begin
    win_next[0] = data_byte;
    for (int k = 1; k < int'(MAX_PATTERN_BYTES); k++) begin
      win_next[k] = ctl.last ? 8'h00 : win[k-1];
    end
    if (ctl.last) begin
      seen_next = SEEN_W'(1);
      pos_next  = '0;
    end else begin
      seen_next = (seen == SEEN_TOP) ? seen : seen + SEEN_W'(1);
      pos_next  = (pos == POS_TOP) ? pos : pos + OFFSET_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
      ctl.last  <= 1'b1;
    end else if (accept) begin
      ctl.valid <= 1'b1;
      ctl.last  <= last_byte;
    end else if (take) begin
      ctl.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win  <= win_next;
      seen <= seen_next;
      pos  <= pos_next;
    end
  end

endmodule

>>> hw/rtl/mbps_matcher.sv
// Masked window compare, start offset arithmetic and the result register.
// Depends on mbps_pkg for the configuration and stage control structs.
module mbps_matcher #(
  parameter int unsigned MAX_PATTERN_BYTES = 32,
  parameter int unsigned OFFSET_BITS       = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  mbps_pkg::cfg_t                         cfg,
  input  mbps_pkg::stage_ctl_t                   ctl,
  input  logic [MAX_PATTERN_BYTES-1:0][7:0]      win,
  input  logic [$clog2(MAX_PATTERN_BYTES+1)-1:0] seen,
  input  logic [OFFSET_BITS-1:0]                 pos,
  output logic                                   take,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   match_found,
  output logic [31:0]                            match_offset,
  output logic                                   buffer_done
);

  localparam int unsigned NB     = mbps_pkg::PAT_BYTES;
  localparam int unsigned CMP_W  = mbps_pkg::CNT_CMP_W;
  localparam int unsigned LIMIT  = (MAX_PATTERN_BYTES < NB) ? MAX_PATTERN_BYTES : NB;
  localparam logic [OFFSET_BITS-1:0] POS_TOP = '1;

  logic [NB-1:0][7:0]          w32;
  logic [NB-1:0]               mism;
  logic                        len_ok;
  logic                        seen_ok;
  logic                        hit;
  logic [OFFSET_BITS-1:0]      len_m1;
  logic [OFFSET_BITS-1:0]      offset;
  logic [OFFSET_BITS+31:0]     offset_ext;

  // Window entries beyond the configured depth read as zero; they are never
  // compared because the length check rejects such patterns.
  for (genvar k = 0; k < NB; k++) begin : g_w32
    if (k < MAX_PATTERN_BYTES) begin : g_in
      assign w32[k] = win[k];
    end else begin : g_out
      assign w32[k] = 8'h00;
    end
  end

  // Pattern byte i lines up with window entry len-1-i (entry 0 is newest).
  always_comb begin
    logic [4:0] idx;
    for (int i = 0; i < int'(NB); i++) begin
      idx     = cfg.length[4:0] - 5'd1 - 5'(i);
      mism[i] = (6'(i) < cfg.length) && cfg.care[i] && (w32[idx] != cfg.pattern[i]);
    end
  end

  assign len_ok  = (cfg.length != '0) && ({1'b0, cfg.length} <= 7'(LIMIT));
  assign seen_ok = CMP_W'(seen) >= CMP_W'(cfg.length);
  assign hit     = len_ok & seen_ok & ~(|mism);
  assign len_m1  = OFFSET_BITS'(cfg.length) - OFFSET_BITS'(1);

  always_comb begin
    if (!hit) begin
      offset = '0;
    end else if (pos == POS_TOP) begin
      offset = POS_TOP;
    end else if (pos >= len_m1) begin
      offset = pos - len_m1;
    end else begin
      offset = '0;
    end
  end

  assign offset_ext = {32'd0, offset};
  assign take       = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && ctl.valid) begin
      match_found  <= hit;
      match_offset <= offset_ext[31:0];
      buffer_done  <= ctl.last;
    end
  end

endmodule

>>> hw/rtl/masked_byte_pattern_search_top.sv
// Top level of the masked byte pattern search: register file, window stage, matcher.
// Depends on mbps_pkg, mbps_cfg_regs, mbps_window and mbps_matcher.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-------------------------------------------
//  config   | psel/penable/pready  | pwrite, paddr, pwdata, prdata (64 bits)
//  input    | in_valid/in_ready    | data_byte, last_byte
//  result   | out_valid/out_ready  | match_found, match_offset, buffer_done
//
// Every request gives exactly one result. A request accepted at the input is
// held in the window stage and is loaded into the result register once that
// register is free or being read; out_valid rises with that load. The masked compare
// of up to 32 window bytes and the offset subtract sit between those two
// registers, so one byte is taken on every clock while the result side keeps up.
// When the result register is full and not taken, the window stage holds its
// request and in_ready drops; nothing is lost or repeated under stalls.
// Reset is synchronous; it clears the configuration and the valid flags and sets
// the last flag, so the first byte after reset starts a fresh buffer. Configuration
// is meant to change only while no request is in flight.
module masked_byte_pattern_search_top #(
  parameter int unsigned MAX_PATTERN_BYTES = 32,
  parameter int unsigned OFFSET_BITS       = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mbps_pkg::ADDR_W-1:0] paddr,
  input  logic [mbps_pkg::DATA_W-1:0] pwdata,
  output logic [mbps_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  data_byte,
  input  logic                        last_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        match_found,
  output logic [31:0]                 match_offset,
  output logic                        buffer_done
);

  localparam int unsigned SEEN_W = $clog2(MAX_PATTERN_BYTES + 1);

  mbps_pkg::cfg_t                    cfg;
  mbps_pkg::stage_ctl_t              ctl;
  logic [MAX_PATTERN_BYTES-1:0][7:0] win;
  logic [SEEN_W-1:0]                 seen;
  logic [OFFSET_BITS-1:0]            pos;
  logic                              take;

  // Configuration registers on the APB-style port.
  mbps_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Window stage: shifts each accepted byte in and tracks count and offset.
  mbps_window #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .OFFSET_BITS       (OFFSET_BITS)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .take      (take),
    .ctl       (ctl),
    .win       (win),
    .seen      (seen),
    .pos       (pos)
  );

  // Matcher: compare against the pattern and register the result.
  mbps_matcher #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .OFFSET_BITS       (OFFSET_BITS)
  ) u_matcher (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .ctl          (ctl),
    .win          (win),
    .seen         (seen),
    .pos          (pos),
    .take         (take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .match_found  (match_found),
    .match_offset (match_offset),
    .buffer_done  (buffer_done)
  );

  // An accepted request always occupies the window stage on the next cycle.
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> ctl.valid)
    else $error("accepted request did not reach the window stage");

  // Input back-pressure only comes from a full window stage.
  a_ready_only_when_free: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> ctl.valid && !take)
    else $error("in_ready low while the window stage could move");

  // A result without a match always carries a zero offset.
  a_no_match_zero_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && !match_found |-> match_offset == 32'd0)
    else $error("nonzero offset on a result without a match");

  // A zero pattern length never yields a match.
  a_zero_length_no_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && cfg.length == '0 |-> !match_found)
    else $error("match reported with a zero pattern length");

endmodule

>>> tb/sv/mbps_search_tb_pkg.sv
`timescale 1ns / 100ps
// Result type and scoreboard for the masked byte pattern search testbench.
// Depends on mbps_pkg for the pattern width and the register index names.
package mbps_search_tb_pkg;

  localparam logic [31:0] OFFSET_TOP = 32'hFFFF_FFFF;

  // Addresses above the length register that decode to no register.
  localparam logic [2:0] UNUSED_IDX_LO = 3'd6;
  localparam logic [2:0] UNUSED_IDX_HI = 3'd7;

  typedef struct packed {
    logic        found;
    logic [31:0] offset;
    logic        done;
  } match_result_t;

  class pattern_match_scoreboard;
    logic [mbps_pkg::PAT_BYTES-1:0][7:0] pat;
    logic [31:0]                         care;
    logic [mbps_pkg::LEN_W-1:0]          len;
    logic [7:0]                          window [mbps_pkg::PAT_BYTES];
    int unsigned                         seen;
    logic [31:0]                         pos;
    match_result_t                       expected_matches [$];
    int unsigned                         errors;
    int unsigned                         requests;
    int unsigned                         match_count;

    function new();
      pat         = '0;
      care        = '0;
      len         = '0;
      errors      = 0;
      requests    = 0;
      match_count = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      foreach (window[k]) window[k] = 8'h00;
      seen = 0;
      pos  = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] value);
      case (idx)
        mbps_pkg::REG_PATTERN0: pat[7:0]   = value;
        mbps_pkg::REG_PATTERN1: pat[15:8]  = value;
        mbps_pkg::REG_PATTERN2: pat[23:16] = value;
        mbps_pkg::REG_PATTERN3: pat[31:24] = value;
        mbps_pkg::REG_CARE:     care       = value[31:0];
        mbps_pkg::REG_LENGTH:   len        = value[mbps_pkg::LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // Shift the byte in, run the masked compare and queue the result it yields.
    function void predict_byte(logic [7:0] data, logic last);
      match_result_t r;
      bit            hit;
      int            len_i;
      int            k;
      len_i = int'(len);
      for (k = mbps_pkg::PAT_BYTES - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = data;
      if (seen < mbps_pkg::PAT_BYTES) seen++;
      // Pattern byte 0 lines up with the oldest byte of the matched span.
      hit = (len_i != 0) && (len_i <= mbps_pkg::PAT_BYTES) && (seen >= len_i);
      for (k = 0; hit && k < len_i; k++) begin
        if (care[k] && window[len_i-1-k] != pat[k]) hit = 0;
      end
      r.found  = hit;
      r.offset = '0;
      if (hit) begin
        if (pos == OFFSET_TOP) r.offset = OFFSET_TOP;
        else if (pos >= 32'(len_i - 1)) r.offset = pos - 32'(len_i - 1);
      end
      if (pos != OFFSET_TOP) pos++;
      r.done = last;
      if (last) clear_scan();
      expected_matches.insert(expected_matches.size(), r);
      requests++;
    endfunction

    function void check_result(logic found, logic [31:0] offset, logic done);
      match_result_t e;
      if (expected_matches.size() == 0) begin
        $display("%0t: unexpected result found=%0b offset=%0d done=%0b",
                 $time, found, offset, done);
        errors++;
        return;
      end
      e = expected_matches.pop_front();
      if (found !== e.found) begin
        $display("%0t: match_found expected %0b, got %0b", $time, e.found, found);
        errors++;
      end
      if (offset !== e.offset) begin
        $display("%0t: match_offset expected %0d, got %0d", $time, e.offset, offset);
        errors++;
      end
      if (done !== e.done) begin
        $display("%0t: buffer_done expected %0b, got %0b", $time, e.done, done);
        errors++;
      end
      if (found === 1'b1) match_count++;
    endfunction

    function int unsigned pending();
      return expected_matches.size();
    endfunction
  endclass

endpackage

>>> tb/sv/tb_masked_byte_pattern_search_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for masked_byte_pattern_search_top.
// Depends on mbps_pkg, mbps_search_tb_pkg and the block's RTL.
module tb_masked_byte_pattern_search_top;

  // The block takes one request per cycle while the receiver keeps up, so this
  // limit is many times the slowest correct run with both sides stalling.
  localparam int unsigned CYCLE_LIMIT = 400_000;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        psel      = 1'b0;
  logic                        penable   = 1'b0;
  logic                        pwrite    = 1'b0;
  logic [mbps_pkg::ADDR_W-1:0] paddr     = '0;
  logic [mbps_pkg::DATA_W-1:0] pwdata    = '0;
  logic [mbps_pkg::DATA_W-1:0] prdata;
  logic                        pready;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  logic [7:0]                  data_byte = 8'h00;
  logic                        last_byte = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b1;
  logic                        match_found;
  logic [31:0]                 match_offset;
  logic                        buffer_done;

  // When set, neither the sender nor the receiver inserts any idle cycles.
  bit                no_idle   = 1'b0;
  int unsigned       cycles    = 0;
  int unsigned       settings  = 0;

  mbps_search_tb_pkg::pattern_match_scoreboard match_sb = new();

  masked_byte_pattern_search_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .match_found  (match_found),
    .match_offset (match_offset),
    .buffer_done  (buffer_done)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The run is bounded: if the block stops answering, this ends it as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycles, match_sb.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // The receiver stalls at random, about nine times in a hundred. It changes
  // only on the falling edge so the block sees a stable value at the rising edge.
  always @(negedge clk) begin
    out_ready <= (rst || no_idle) ? 1'b1 : ($urandom_range(99) >= 9);
  end

  // Every result taken at a rising edge is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      match_sb.check_result(match_found, match_offset, buffer_done);
    end
  end

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // A pattern word made only of all-zero and all-one bytes.
  function automatic logic [63:0] extreme_word();
    logic [63:0] w;
    for (int j = 0; j < 8; j++) w[8*j +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
    return w;
  endfunction

  // One register write: a setup phase, then an access phase that completes at
  // the rising edge where pready is high. The local copy follows the block.
  // The bus then rests idle before the next write may start.
  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    match_sb.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Offers one request and returns on the falling edge after it was accepted.
  // Idle cycles go in front of the request, never in the middle of one, so
  // valid is not dropped while a request is waiting.
  task automatic send_byte(logic [7:0] data, logic last);
    if (!no_idle) begin
      while ($urandom_range(99) < 9) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid  <= 1'b1;
    data_byte <= data;
    last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    match_sb.predict_byte(data, last);
    @(negedge clk);
  endtask

  // Stops offering requests and waits until every prediction has been met.
  // Each request gives a result, so a short pause then leaves the block idle.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (match_sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes every register. Care mask and length get random upper bits that
  // the block must drop.
  task automatic program_all(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                             logic [63:0] w3, logic [31:0] care, logic [5:0] len);
    quiesce();
    write_reg(mbps_pkg::REG_PATTERN0, w0);
    write_reg(mbps_pkg::REG_PATTERN1, w1);
    write_reg(mbps_pkg::REG_PATTERN2, w2);
    write_reg(mbps_pkg::REG_PATTERN3, w3);
    write_reg(mbps_pkg::REG_CARE, {$urandom, care});
    write_reg(mbps_pkg::REG_LENGTH, {$urandom, 26'($urandom), len});
    settings++;
  endtask

  function automatic int unsigned pick_buffer_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 48);
    else if (r < 95) return $urandom_range(49, 160);
    return $urandom_range(161, 400);
  endfunction

  // Random traffic for the current setting. Most segments are copies of the
  // pattern with random bytes in the wildcard positions, sometimes with one
  // byte spoiled; the rest are cut-off prefixes and plain noise. Buffer ends
  // fall wherever the random buffer length runs out, mid-pattern included.
  task automatic scan_phase(int unsigned n_items);
    logic [7:0]  seg [$];
    int unsigned left_in_buf;
    int unsigned sent;
    int unsigned plen;
    int unsigned cut;
    int unsigned r;
    left_in_buf = pick_buffer_len();
    sent = 0;
    while (sent < n_items) begin
      seg.delete();
      // An unusable length still gets pattern-like segments of a few bytes.
      plen = (match_sb.len >= 1 && match_sb.len <= mbps_pkg::PAT_BYTES) ?
             match_sb.len : $urandom_range(1, 8);
      r = $urandom_range(99);
      if (r < 60) begin
        for (int k = 0; k < plen; k++) begin
          seg.insert(seg.size(), match_sb.care[k] ? match_sb.pat[k] : 8'($urandom));
        end
        if ($urandom_range(9) == 0) begin
          cut = $urandom_range(plen - 1);
          seg[cut] = seg[cut] ^ 8'($urandom_range(1, 255));
        end
      end else if (r < 70) begin
        cut = $urandom_range(plen - 1);
        for (int k = 0; k < cut; k++) begin
          seg.insert(seg.size(), match_sb.care[k] ? match_sb.pat[k] : 8'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 6)) seg.insert(seg.size(), 8'($urandom));
      end
      foreach (seg[k]) begin
        send_byte(seg[k], left_in_buf == 1);
        sent++;
        left_in_buf--;
        if (left_in_buf == 0) left_in_buf = pick_buffer_len();
      end
    end
  endtask

  initial begin
    logic [7:0]  rep;
    logic [63:0] rep_word;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Registers come out of reset at zero, so the length is zero and nothing
    // may match, not even an all-zero byte against the all-zero pattern.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b1);
    quiesce();

    // Writes to addresses past the last register must change nothing.
    write_reg(mbps_search_tb_pkg::UNUSED_IDX_LO, '1);
    write_reg(mbps_search_tb_pkg::UNUSED_IDX_HI, '1);

    // One-byte pattern: every 0xFF matches on its own, and the offset restarts
    // after the buffer end. Care bits beyond the length are set but unused.
    program_all('1, '1, '1, '1, '1, 6'd1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);

    // Three bytes with a wildcard in the middle. Two matches overlap on a
    // shared byte. Pattern bytes past the length hold junk and are ignored.
    program_all(64'h5A5A_5A5A_5A41_7741, '0, '1, '0, 32'hFFFF_FFF5, 6'd3);
    send_byte(8'h41, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h41, 1'b1);

    // Lengths beyond the pattern store never match, even with no byte cared for.
    program_all('0, '0, '0, '0, '0, 6'd33);
    send_byte(8'h00, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'hFF, 1'b0);
    program_all('0, '0, '0, '0, '0, 6'd63);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    // Random part: full-length patterns first, then one setting run with no
    // idling at all, then overlaps, wildcards and the disabled lengths.
    program_all(random_word(), random_word(), random_word(), random_word(), '1, 6'd32);
    scan_phase(240);
    program_all(random_word(), random_word(), random_word(), random_word(),
                $urandom, 6'd32);
    scan_phase(240);

    program_all(random_word(), random_word(), random_word(), random_word(), '1, 6'd1);
    no_idle = 1'b1;
    scan_phase(240);
    quiesce();
    no_idle = 1'b0;

    program_all(random_word(), random_word(), random_word(), random_word(),
                $urandom, 6'($urandom_range(2, 31)));
    scan_phase(240);

    // A run of identical bytes matches at every position once it spans the pattern length.
    rep = 8'($urandom);
    rep_word = {8{rep}};
    program_all(rep_word, rep_word, rep_word, rep_word, '1, 6'd5);
    scan_phase(200);

    program_all(random_word(), random_word(), random_word(), random_word(), '0, 6'd8);
    scan_phase(200);
    program_all('0, '0, '0, '0, '1, 6'd0);
    scan_phase(120);
    program_all('1, '1, '1, '1, '1, 6'($urandom_range(33, 63)));
    scan_phase(120);
    program_all(extreme_word(), extreme_word(), extreme_word(), extreme_word(),
                $urandom, 6'($urandom_range(1, 32)));
    scan_phase(300);

    // Drain, then give the block time to show any result nobody asked for.
    in_valid <= 1'b0;
    while (match_sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d requests over %0d register settings; %0d matches reported.",
             match_sb.requests, settings, match_sb.match_count);
    $display("%0d field mismatches or unexpected results.", match_sb.errors);
    if (match_sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_cfg_regs.sv
hw/rtl/mbps_window.sv
hw/rtl/mbps_matcher.sv
hw/rtl/masked_byte_pattern_search_top.sv
tb/sv/mbps_search_tb_pkg.sv
tb/sv/tb_masked_byte_pattern_search_top.sv
